/* rtl/pida_pkg.sv */
package pida_pkg;

    // number of cells in the chain
    localparam int DEPTH = 32;

    // widths fixed by the item format
    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int ECOUNT_W = 6;
    localparam int STATUS_W = 2;

    // internal count and cell index width
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR   = 3'd0,
        KIND_APPEND  = 3'd1,
        KIND_INSERT  = 3'd2,
        KIND_DELETE  = 3'd3,
        KIND_DISPLAY = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } t_cell_op;

    // command broadcast to every cell
    typedef struct packed {
        t_cell_op                  op;
        logic [CNT_W-1:0]          pos;
        logic [CNT_W-1:0]          count;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

/* rtl/positional_insert_delete_array_top.sv */
// ordered store of up to pida_pkg::DEPTH signed 32-bit entries, kept in a row
// of cells; cell k holds entry k. clear, append, insert and delete each take
// one transfer in and give one transfer out, and the store is updated in the
// cycle of the input transfer: insert and delete move every later cell one
// place in parallel. display gives one output transfer per stored entry, in
// order, with o_last on the final one; the chain rotates one place toward
// the head for each entry shown, so after count steps the store is back in
// its original order. a display therefore holds the input side until its
// final entry has been loaded into the output register, while no other item
// kind holds it. an input transfer is taken whenever no display is
// running and the output register is empty or being drained. failing
// requests (full store, position out of range, empty store) leave the store
// unchanged and report the status code with a zero value and index
module positional_insert_delete_array_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pida_pkg::KIND_W-1:0]         i_kind,
    input  logic [pida_pkg::POS_W-1:0]          i_position,
    input  logic signed [pida_pkg::VALUE_W-1:0] i_item_value,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [pida_pkg::VALUE_W-1:0] o_out_value,
    output logic [pida_pkg::POS_W-1:0]          o_out_index,
    output logic [pida_pkg::ECOUNT_W-1:0]       o_entry_count,
    output logic [pida_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_last
);

    // controller state: idle, or stepping through a display
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [pida_pkg::CNT_W-1:0]  r_count, n_count;
    logic [pida_pkg::CNT_W-1:0]  r_disp_idx, n_disp_idx;

    // output register
    logic                                r_out_valid;
    logic signed [pida_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    logic [pida_pkg::POS_W-1:0]          r_out_index, n_out_index;
    logic [pida_pkg::ECOUNT_W-1:0]       r_entry_count;
    pida_pkg::t_status                   r_status, n_status;
    logic                                r_last, n_last;
    logic                                w_load;

    // cell chain
    pida_pkg::t_cell_ctl                 w_ctl;
    logic signed [pida_pkg::VALUE_W-1:0] w_cell [pida_pkg::DEPTH];
    logic signed [pida_pkg::VALUE_W-1:0] w_removed;

    logic                        w_out_free;
    logic                        w_accept;
    logic                        w_show_step;
    logic                        w_full;
    logic [pida_pkg::CNT_W-1:0]  w_pos;
    logic                        w_last_entry;

    // output slot can take a new result this cycle
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(r_state == ST_IDLE && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_show_step = (r_state == ST_SHOW) && w_out_free;

    assign w_full = (r_count >= pida_pkg::CNT_W'(pida_pkg::DEPTH));
    assign w_pos  = pida_pkg::CNT_W'(i_position);
    assign w_last_entry = ((r_disp_idx + pida_pkg::CNT_W'(1)) == r_count);

    // pick the entry at the requested position for delete
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < pida_pkg::DEPTH; k++) begin
            if (pida_pkg::CNT_W'(k) == w_pos) begin
                w_removed = w_cell[k];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_disp_idx  = r_disp_idx;
        w_load      = 1'b0;
        n_out_value = '0;
        n_out_index = '0;
        n_status    = pida_pkg::STATUS_OK;
        n_last      = 1'b1;
        w_ctl.op    = pida_pkg::CELL_HOLD;
        w_ctl.pos   = w_pos;
        w_ctl.count = r_count;
        w_ctl.value = i_item_value;

        if (w_accept) begin
            w_load = 1'b1;
            case (i_kind)
                pida_pkg::KIND_CLEAR: begin
                    n_count = '0;
                end
                pida_pkg::KIND_APPEND: begin
                    if (w_full) begin
                        n_status = pida_pkg::STATUS_FULL;
                    end else begin
                        w_ctl.op = pida_pkg::CELL_APPEND;
                        n_count  = r_count + pida_pkg::CNT_W'(1);
                    end
                end
                pida_pkg::KIND_INSERT: begin
                    // fullness wins over a bad position
                    if (w_full) begin
                        n_status = pida_pkg::STATUS_FULL;
                    end else if (w_pos > r_count) begin
                        n_status = pida_pkg::STATUS_RANGE;
                    end else begin
                        w_ctl.op = pida_pkg::CELL_INSERT;
                        n_count  = r_count + pida_pkg::CNT_W'(1);
                    end
                end
                pida_pkg::KIND_DELETE: begin
                    if (r_count == '0) begin
                        n_status = pida_pkg::STATUS_EMPTY;
                    end else if (w_pos >= r_count) begin
                        n_status = pida_pkg::STATUS_RANGE;
                    end else begin
                        w_ctl.op    = pida_pkg::CELL_DELETE;
                        n_count     = r_count - pida_pkg::CNT_W'(1);
                        n_out_value = w_removed;
                        n_out_index = i_position;
                    end
                end
                pida_pkg::KIND_DISPLAY: begin
                    if (r_count == '0) begin
                        n_status = pida_pkg::STATUS_EMPTY;
                    end else begin
                        // entries go out one by one in the display steps that follow
                        w_load     = 1'b0;
                        n_state    = ST_SHOW;
                        n_disp_idx = '0;
                    end
                end
                default: begin
                    // unused kinds only report the current count
                    n_status = pida_pkg::STATUS_OK;
                end
            endcase
        end else if (w_show_step) begin
            // head cell goes out, chain rotates one place
            w_load      = 1'b1;
            w_ctl.op    = pida_pkg::CELL_ROTATE;
            n_out_value = w_cell[0];
            n_out_index = pida_pkg::POS_W'(r_disp_idx);
            n_last      = w_last_entry;
            n_disp_idx  = r_disp_idx + pida_pkg::CNT_W'(1);
            if (w_last_entry) begin
                n_state = ST_IDLE;
            end
        end
    end

    // the chain of cells
    for (genvar g = 0; g < pida_pkg::DEPTH; g++) begin : g_cell
        logic signed [pida_pkg::VALUE_W-1:0] w_left;
        logic signed [pida_pkg::VALUE_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end

        if (g == pida_pkg::DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end

        pida_cell u_cell (
            .i_clk   (i_clk),
            .i_index (pida_pkg::CNT_W'(g)),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_first (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_disp_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_disp_idx <= n_disp_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value   <= n_out_value;
            r_out_index   <= n_out_index;
            r_entry_count <= pida_pkg::ECOUNT_W'(n_count);
            r_status      <= n_status;
            r_last        <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = r_out_value;
    assign o_out_index   = r_out_index;
    assign o_entry_count = r_entry_count;
    assign o_status      = r_status;
    assign o_last        = r_last;

endmodule

/* rtl/pida_cell.sv */
module pida_cell (
    input  logic                               i_clk,
    input  logic [pida_pkg::CNT_W-1:0]         i_index,
    input  pida_pkg::t_cell_ctl                i_ctl,
    input  logic signed [pida_pkg::VALUE_W-1:0] i_left,
    input  logic signed [pida_pkg::VALUE_W-1:0] i_right,
    input  logic signed [pida_pkg::VALUE_W-1:0] i_first,
    output logic signed [pida_pkg::VALUE_W-1:0] o_value
);

    logic signed [pida_pkg::VALUE_W-1:0] r_value;
    logic signed [pida_pkg::VALUE_W-1:0] n_value;
    logic [pida_pkg::CNT_W-1:0]          w_next_index;

    assign w_next_index = i_index + pida_pkg::CNT_W'(1);

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            pida_pkg::CELL_APPEND: begin
                if (i_index == i_ctl.count) begin
                    n_value = i_ctl.value;
                end
            end
            pida_pkg::CELL_INSERT: begin
                if (i_index == i_ctl.pos) begin
                    n_value = i_ctl.value;
                end else if (i_index > i_ctl.pos && i_index <= i_ctl.count) begin
                    n_value = i_left;
                end
            end
            pida_pkg::CELL_DELETE: begin
                if (i_index >= i_ctl.pos && w_next_index < i_ctl.count) begin
                    n_value = i_right;
                end
            end
            pida_pkg::CELL_ROTATE: begin
                // last occupied cell takes the head entry, the other occupied cells move one toward the head
                if (w_next_index < i_ctl.count) begin
                    n_value = i_right;
                end else if (w_next_index == i_ctl.count) begin
                    n_value = i_first;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
